[src/lcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants for the two-zone Langevin force pipeline.
// ----------------------------------------------------------------------------
package lcf_pkg;

    localparam int NUM_PLANES_DEF = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int DIV_STEPS      = 48;
    localparam int SQRT_STEPS     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_THICK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SECOND = 3'd7;

    localparam logic [31:0] DAMP_RESET        = 32'd6554;
    localparam logic [31:0] TEMP_RESET        = 32'd0;
    localparam logic [31:0] NOISE_RESET       = 32'd0;
    localparam logic [31:0] INV_THICK_RESET   = 32'd65536;
    localparam logic [63:0] PLANE_FIRST_RESET = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PLANE_SECOND_RESET = 64'h0;

    // per-particle data that rides along the pipeline
    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][15:0] noise;
        logic [31:0]      mass;
    } side_t;

    // blend coefficients from the register file
    typedef struct packed {
        logic [31:0] damp_a;
        logic [31:0] damp_b;
        logic [31:0] temp_a;
        logic [31:0] temp_b;
        logic [31:0] noise_factor;
    } coef_t;

endpackage

[src/lcf_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_dist
// Plane distance, minimum over used planes, layer weight t (Q1.16). 5 stages.
// ----------------------------------------------------------------------------
module lcf_dist
    import lcf_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [NUM_PLANES-1:0][63:0] plane,
    input  logic [31:0]                inv_thickness,
    input  logic [2:0][31:0]           pos,
    input  side_t                      in_side,
    output logic                       out_valid,
    output logic [16:0]                t,
    output side_t                      out_side
);

    logic [4:0]         vld_reg;
    side_t              side_reg [5];

    logic signed [47:0] prod_reg [NUM_PLANES][3];
    logic [15:0]        off_reg  [NUM_PLANES];
    logic [NUM_PLANES-1:0] used1_reg;

    logic signed [50:0] dist_reg [NUM_PLANES];
    logic [NUM_PLANES-1:0] used2_reg;

    logic [36:0]        d16_reg;
    logic               any3_reg;
    logic               neg3_reg;

    logic [32:0]        p_reg;
    logic               any4_reg;
    logic               neg4_reg;

    logic [16:0]        t_reg;

    logic               any_c;
    logic signed [50:0] best_c;
    logic [50:0]        mag_c;
    logic [63:0]        prod64_c;
    logic [32:0]        p_c;
    logic [33:0]        tsum_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_comb
    begin
        any_c  = 1'b0;
        best_c = '0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            if (used2_reg[p])
            begin
                if (!any_c || (dist_reg[p] < best_c))
                begin
                    best_c = dist_reg[p];
                end
                any_c = 1'b1;
            end
        end
        mag_c = best_c[50] ? 51'(-best_c) : 51'(best_c);
    end

    always_comb
    begin
        prod64_c = 64'(d16_reg[31:0]) * 64'(inv_thickness);
        if (inv_thickness == 32'd0)
        begin
            p_c = '0;
        end
        else if (|d16_reg[36:32])
        begin
            p_c = 33'h1_0000_0000;
        end
        else if (prod64_c > 64'h1_0000_0000)
        begin
            p_c = 33'h1_0000_0000;
        end
        else
        begin
            p_c = prod64_c[32:0];
        end
    end

    assign tsum_c = neg4_reg ? (34'h1_0000_0000 - {1'b0, p_reg})
                             : (34'h1_0000_0000 + {1'b0, p_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < 5; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end

            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[p][k] <= $signed(plane[p][63-16*k -: 16]) * $signed(pos[k]);
                end
                off_reg[p]   <= plane[p][15:0];
                used1_reg[p] <= |plane[p];
            end

            for (int p = 0; p < NUM_PLANES; p++)
            begin
                dist_reg[p] <= 51'(prod_reg[p][0]) + 51'(prod_reg[p][1])
                             + 51'(prod_reg[p][2])
                             + $signed({{13{off_reg[p][15]}}, off_reg[p], 22'b0});
            end
            used2_reg <= used1_reg;

            d16_reg  <= mag_c[50:14];
            any3_reg <= any_c;
            neg3_reg <= best_c[50];

            p_reg    <= p_c;
            any4_reg <= any3_reg;
            neg4_reg <= neg3_reg;

            t_reg <= any4_reg ? tsum_c[33:17] : 17'd65536;
        end
    end

    assign out_valid = vld_reg[4];
    assign t         = t_reg;
    assign out_side  = side_reg[4];

endmodule

[src/lcf_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_blend
// Blends damping and temperature by t, then forms a = noise_factor*T. 3 stages.
// ----------------------------------------------------------------------------
module lcf_blend
    import lcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  coef_t       coef,
    input  logic [16:0] t,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] damp,
    output logic [31:0] a,
    output side_t       out_side
);

    logic [2:0]  vld_reg;
    side_t       side_reg [3];

    logic [48:0] pda_reg, pdb_reg, pta_reg, ptb_reg;
    logic [31:0] damp2_reg, temp2_reg;
    logic [31:0] damp3_reg, a3_reg;

    logic [16:0] wa_c;
    logic [49:0] sd_c, st_c;
    logic [63:0] pa_c;

    assign wa_c = 17'd65536 - t;
    assign sd_c = 50'(pda_reg) + 50'(pdb_reg);
    assign st_c = 50'(pta_reg) + 50'(ptb_reg);
    assign pa_c = 64'(coef.noise_factor) * 64'(temp2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];

            pda_reg <= 49'(wa_c) * 49'(coef.damp_a);
            pdb_reg <= 49'(t) * 49'(coef.damp_b);
            pta_reg <= 49'(wa_c) * 49'(coef.temp_a);
            ptb_reg <= 49'(t) * 49'(coef.temp_b);

            // a blended damp of zero counts as one LSB
            damp2_reg <= (sd_c[47:16] == 32'd0) ? 32'd1 : sd_c[47:16];
            temp2_reg <= st_c[47:16];

            damp3_reg <= damp2_reg;
            a3_reg    <= pa_c[63:32];
        end
    end

    assign out_valid = vld_reg[2];
    assign damp      = damp3_reg;
    assign a         = a3_reg;
    assign out_side  = side_reg[2];

endmodule

[src/lcf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_div
// Pipelined restoring divider: r = (mass << 16) / damp, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module lcf_div
    import lcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] damp,
    input  logic [31:0] a,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [47:0] r,
    output logic [31:0] a_out,
    output side_t       out_side
);

    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] quo;
        logic [31:0] damp;
        logic [31:0] a;
        side_t       side;
    } div_t;

    logic [DIV_STEPS-1:0] vld_reg;
    div_t                 st_reg [DIV_STEPS];
    div_t                 init_c;

    always_comb
    begin
        init_c      = '0;
        init_c.damp = damp;
        init_c.a    = a;
        init_c.side = in_side;
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        div_t        cur;
        div_t        nxt;
        logic        dbit;
        logic [32:0] trial;

        if (s == 0)
        begin : g_first
            assign cur = init_c;
        end
        else
        begin : g_next
            assign cur = st_reg[s-1];
        end

        if (DIV_STEPS - 1 - s >= 16)
        begin : g_mbit
            assign dbit = cur.side.mass[DIV_STEPS - 1 - s - 16];
        end
        else
        begin : g_zbit
            assign dbit = 1'b0;
        end

        assign trial = {cur.rem, dbit};

        always_comb
        begin
            nxt = cur;
            if (trial >= {1'b0, cur.damp})
            begin
                nxt.rem = 32'(trial - {1'b0, cur.damp});
                nxt.quo[DIV_STEPS-1-s] = 1'b1;
            end
            else
            begin
                nxt.rem = trial[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign r         = st_reg[DIV_STEPS-1].quo;
    assign a_out     = st_reg[DIV_STEPS-1].a;
    assign out_side  = st_reg[DIV_STEPS-1].side;

endmodule

[src/lcf_force.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_force
// Friction and noise amplitude products, pipelined square root, then the
// per-axis sum with saturation into the output register. 36 stages.
// ----------------------------------------------------------------------------
module lcf_force
    import lcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [47:0]      r,
    input  logic [31:0]      a,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [2:0][31:0] dforce
);

    localparam int NSTG = SQRT_STEPS + 4;

    typedef struct packed {
        logic [33:0]      rem;
        logic [31:0]      root;
        logic [47:0]      x;
        logic [2:0][33:0] fm;
        logic [2:0]       vneg;
        logic [2:0][15:0] noise;
    } sq_t;

    logic [NSTG-1:0]  vld_reg;

    // multiply stage
    logic [63:0]      pb1_reg;
    logic [47:0]      pb2_reg;
    logic [63:0]      pf1_reg [3];
    logic [47:0]      pf2_reg [3];
    logic [2:0]       vneg1_reg;
    logic [2:0][15:0] noise1_reg;

    // sum and cap stage
    sq_t              sq0_reg;
    sq_t              sq_reg [SQRT_STEPS];

    // noise amplitude stage
    logic [2:0][35:0] rm_reg;
    logic [2:0][33:0] fm_n_reg;
    logic [2:0]       vneg_n_reg;
    logic [2:0]       nneg_n_reg;

    logic [2:0][31:0] out_reg;

    logic [2:0][31:0] vm_c;
    logic [63:0]      b_c;
    logic [63:0]      fmw_c [3];
    sq_t              sq0_c;
    sq_t              last_c;
    logic [2:0][15:0] nmag_c;
    logic [2:0][47:0] rprod_c;
    logic signed [37:0] fric_c [3];
    logic signed [37:0] rnd_c [3];
    logic signed [37:0] tot_c [3];
    logic [2:0][31:0] sat_c;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vm_c[k] = in_side.vel[k][31] ? 32'(-in_side.vel[k]) : in_side.vel[k];
        end
    end

    always_comb
    begin
        b_c = pb1_reg + 64'(pb2_reg[47:16]);
        sq0_c       = '0;
        sq0_c.x     = (b_c > 64'h0000_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : b_c[47:0];
        sq0_c.vneg  = vneg1_reg;
        sq0_c.noise = noise1_reg;
        for (int k = 0; k < 3; k++)
        begin
            fmw_c[k] = pf1_reg[k] + 64'(pf2_reg[k][47:16]);
            sq0_c.fm[k] = (fmw_c[k] > 64'h2_0000_0000) ? 34'h2_0000_0000
                                                        : fmw_c[k][33:0];
        end
    end

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        sq_t         cur;
        sq_t         nxt;
        logic [63:0] xw;
        logic [35:0] trial;
        logic [35:0] test;

        if (s == 0)
        begin : g_first
            assign cur = sq0_reg;
        end
        else
        begin : g_next
            assign cur = sq_reg[s-1];
        end

        assign xw    = {cur.x, 16'b0};
        assign trial = {cur.rem, xw[2*(SQRT_STEPS-1-s)+1 -: 2]};
        assign test  = {2'b0, cur.root, 2'b01};

        always_comb
        begin
            nxt = cur;
            if (trial >= test)
            begin
                nxt.rem  = 34'(trial - test);
                nxt.root = {cur.root[30:0], 1'b1};
            end
            else
            begin
                nxt.rem  = trial[33:0];
                nxt.root = {cur.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[s] <= nxt;
            end
        end
    end

    assign last_c = sq_reg[SQRT_STEPS-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nmag_c[k]  = last_c.noise[k][15] ? 16'(-last_c.noise[k]) : last_c.noise[k];
            rprod_c[k] = 48'(nmag_c[k]) * 48'(last_c.root);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fric_c[k] = vneg_n_reg[k] ? $signed({4'b0, fm_n_reg[k]})
                                      : -$signed({4'b0, fm_n_reg[k]});
            rnd_c[k]  = nneg_n_reg[k] ? -$signed({2'b0, rm_reg[k]})
                                      : $signed({2'b0, rm_reg[k]});
            tot_c[k]  = fric_c[k] + rnd_c[k];
            if (tot_c[k] > 38'sd2147483647)
            begin
                sat_c[k] = 32'h7FFF_FFFF;
            end
            else if (tot_c[k] < -38'sd2147483648)
            begin
                sat_c[k] = 32'h8000_0000;
            end
            else
            begin
                sat_c[k] = tot_c[k][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb1_reg <= 64'(a) * 64'(r[47:16]);
            pb2_reg <= 48'(a) * 48'(r[15:0]);
            for (int k = 0; k < 3; k++)
            begin
                pf1_reg[k]    <= 64'(vm_c[k]) * 64'(r[47:16]);
                pf2_reg[k]    <= 48'(vm_c[k]) * 48'(r[15:0]);
                vneg1_reg[k]  <= in_side.vel[k][31];
                noise1_reg[k] <= in_side.noise[k];
            end

            sq0_reg <= sq0_c;

            for (int k = 0; k < 3; k++)
            begin
                rm_reg[k]     <= rprod_c[k][47:12];
                fm_n_reg[k]   <= last_c.fm[k];
                vneg_n_reg[k] <= last_c.vneg[k];
                nneg_n_reg[k] <= last_c.noise[k][15];
            end

            out_reg <= sat_c;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign dforce    = out_reg;

endmodule

[src/two_zone_langevin_force.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_zone_langevin_force
// Langevin thermostat force increment per particle, blended over two zones.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one of
//   eight registers; cfg_ready is always high. Write only while idle.
//   Input channel (in_valid/in_ready) takes one particle item: position,
//   velocity, mass and three Gaussian samples.
//   Output channel (out_valid/out_ready) returns one item of three force
//   increments per input item, in order.
// Throughput: one item per cycle, sustained while out_ready stays high.
// Pipeline: from acceptance to out_valid an item passes the plane distance
//   and weight, the blend, the bit-per-stage divider that forms
//   mass/damp, then the products, 32-stage square root and final sum.
// Reset: all valid bits clear, config registers return to their defaults.
// Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module two_zone_langevin_force
    import lcf_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic [31:0]          particle_mass,
    input  logic signed [15:0]   noise_x,
    input  logic signed [15:0]   noise_y,
    input  logic signed [15:0]   noise_z,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   dforce_x,
    output logic signed [31:0]   dforce_y,
    output logic signed [31:0]   dforce_z
);

    logic [31:0] damp_a_reg, damp_b_reg, temp_a_reg, temp_b_reg;
    logic [31:0] noise_factor_reg, inv_thickness_reg;
    logic [63:0] plane_first_reg, plane_second_reg;

    logic                        en;
    logic [NUM_PLANES-1:0][63:0] plane_word;
    coef_t                       coef;
    side_t                       side_in;
    logic [2:0][31:0]            pos;

    logic        d_valid;
    logic [16:0] d_t;
    side_t       d_side;

    logic        b_valid;
    logic [31:0] b_damp;
    logic [31:0] b_a;
    side_t       b_side;

    logic        q_valid;
    logic [47:0] q_r;
    logic [31:0] q_a;
    side_t       q_side;

    logic [2:0][31:0] force_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_a_reg        <= DAMP_RESET;
            damp_b_reg        <= DAMP_RESET;
            temp_a_reg        <= TEMP_RESET;
            temp_b_reg        <= TEMP_RESET;
            noise_factor_reg  <= NOISE_RESET;
            inv_thickness_reg <= INV_THICK_RESET;
            plane_first_reg   <= PLANE_FIRST_RESET;
            plane_second_reg  <= PLANE_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DAMP_A:       damp_a_reg        <= cfg_data[31:0];
                CFG_DAMP_B:       damp_b_reg        <= cfg_data[31:0];
                CFG_TEMP_A:       temp_a_reg        <= cfg_data[31:0];
                CFG_TEMP_B:       temp_b_reg        <= cfg_data[31:0];
                CFG_NOISE_FACTOR: noise_factor_reg  <= cfg_data[31:0];
                CFG_INV_THICK:    inv_thickness_reg <= cfg_data[31:0];
                CFG_PLANE_FIRST:  plane_first_reg   <= cfg_data;
                CFG_PLANE_SECOND: plane_second_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_plane
        if (i == 0)
        begin : g_first
            assign plane_word[i] = plane_first_reg;
        end
        else
        begin : g_second
            assign plane_word[i] = plane_second_reg;
        end
    end

    assign coef.damp_a       = damp_a_reg;
    assign coef.damp_b       = damp_b_reg;
    assign coef.temp_a       = temp_a_reg;
    assign coef.temp_b       = temp_b_reg;
    assign coef.noise_factor = noise_factor_reg;

    assign pos           = {pos_z, pos_y, pos_x};
    assign side_in.vel   = {vel_z, vel_y, vel_x};
    assign side_in.noise = {noise_z, noise_y, noise_x};
    assign side_in.mass  = particle_mass;

    // pipeline advances unless a finished item is held at the output
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    lcf_dist #(
        .NUM_PLANES (NUM_PLANES)
    ) u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .plane         (plane_word),
        .inv_thickness (inv_thickness_reg),
        .pos           (pos),
        .in_side       (side_in),
        .out_valid     (d_valid),
        .t             (d_t),
        .out_side      (d_side)
    );

    lcf_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .coef      (coef),
        .t         (d_t),
        .in_side   (d_side),
        .out_valid (b_valid),
        .damp      (b_damp),
        .a         (b_a),
        .out_side  (b_side)
    );

    lcf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid),
        .damp      (b_damp),
        .a         (b_a),
        .in_side   (b_side),
        .out_valid (q_valid),
        .r         (q_r),
        .a_out     (q_a),
        .out_side  (q_side)
    );

    lcf_force u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .r         (q_r),
        .a         (q_a),
        .in_side   (q_side),
        .out_valid (out_valid),
        .dforce    (force_out)
    );

    assign dforce_x = $signed(force_out[0]);
    assign dforce_y = $signed(force_out[1]);
    assign dforce_z = $signed(force_out[2]);

    a_stall_only_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_cfg_damp_a: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == CFG_DAMP_A)
        |=> damp_a_reg == $past(cfg_data[31:0]))
        else $error("damp_a write lost");

    a_cfg_plane_first: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == CFG_PLANE_FIRST)
        |=> plane_first_reg == $past(cfg_data))
        else $error("plane_first write lost");

endmodule
